// ----- rtl/header_framed_message_deframer_core_defines.svh -----
// Assertion macros used by hfmd_checker.
`ifndef HEADER_FRAMED_MESSAGE_DEFRAMER_CORE_DEFINES_SVH
`define HEADER_FRAMED_MESSAGE_DEFRAMER_CORE_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define HFMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define HFMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hfmd_pkg.sv -----
package hfmd_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int OUT_LEN_W = 24;

    // Error codes carried on the result.
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_LOST     = 3'd1;
    localparam logic [2:0] ERR_BARE_LF  = 3'd2;
    localparam logic [2:0] ERR_CR_NO_LF = 3'd3;
    localparam logic [2:0] ERR_LENGTH   = 3'd4;
    localparam logic [2:0] ERR_TYPE     = 3'd5;
    localparam logic [2:0] ERR_CHARSET  = 3'd6;

    // Type verdicts.
    localparam logic [1:0] TV_OK      = 2'd0;
    localparam logic [1:0] TV_TYPE    = 2'd1;
    localparam logic [1:0] TV_CHARSET = 2'd2;

    localparam logic [3:0] KEY_BAD    = 4'd15;
    localparam logic [4:0] PREFIX_LEN = 5'd26;
    localparam logic [4:0] PREFIX_BAD = 5'd31;
    localparam logic [3:0] CS_BAD     = 4'd15;

    typedef enum logic [4:0] {
        PH_LINE_START = 5'b00001,
        PH_IN_LINE    = 5'b00010,
        PH_LINE_LF    = 5'b00100,
        PH_HEAD_LF    = 5'b01000,
        PH_PAYLOAD    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic                 payload_valid;
        logic [7:0]           payload_byte;
        logic                 message_end;
        logic [2:0]           error_code;
        logic [OUT_LEN_W-1:0] content_length;
    } out_item_t;

    function automatic logic [7:0] lower(input logic [7:0] b);
        lower = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    // Lower-case key text "content-length" and "content-type".
    function automatic logic [7:0] key_len_char(input logic [3:0] p);
        logic [7:0] c;
        case (p)
            4'd0: c = "c"; 4'd1: c = "o"; 4'd2: c = "n"; 4'd3: c = "t";
            4'd4: c = "e"; 4'd5: c = "n"; 4'd6: c = "t"; 4'd7: c = "-";
            4'd8: c = "l"; 4'd9: c = "e"; 4'd10: c = "n"; 4'd11: c = "g";
            4'd12: c = "t"; 4'd13: c = "h";
            default: c = 8'h00;
        endcase
        key_len_char = c;
    endfunction

    function automatic logic [7:0] key_type_char(input logic [3:0] p);
        logic [7:0] c;
        case (p)
            4'd9: c = "y"; 4'd10: c = "p"; 4'd11: c = "e";
            default: c = key_len_char(p);
        endcase
        key_type_char = c;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [4:0] p);
        logic [7:0] c;
        case (p)
            5'd0: c = "a"; 5'd1: c = "p"; 5'd2: c = "p"; 5'd3: c = "l";
            5'd4: c = "i"; 5'd5: c = "c"; 5'd6: c = "a"; 5'd7: c = "t";
            5'd8: c = "i"; 5'd9: c = "o"; 5'd10: c = "n"; 5'd11: c = "/";
            5'd12: c = "v"; 5'd13: c = "s"; 5'd14: c = "c"; 5'd15: c = "o";
            5'd16: c = "d"; 5'd17: c = "e"; 5'd18: c = "-"; 5'd19: c = "j";
            5'd20: c = "s"; 5'd21: c = "o"; 5'd22: c = "n"; 5'd23: c = "r";
            5'd24: c = "p"; 5'd25: c = "c";
            default: c = 8'h00;
        endcase
        prefix_char = c;
    endfunction

    function automatic logic [7:0] charset_char(input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0: c = "c"; 3'd1: c = "h"; 3'd2: c = "a"; 3'd3: c = "r";
            3'd4: c = "s"; 3'd5: c = "e"; 3'd6: c = "t";
            default: c = "=";
        endcase
        charset_char = c;
    endfunction

endpackage

// ----- rtl/hfmd_stream_if.sv -----
interface hfmd_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/hfmd_parse.sv -----
module hfmd_parse
    import hfmd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result
);

    localparam logic [LENGTH_BITS-1:0] LIMIT = {LENGTH_BITS{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic [3:0]             key_reg, key_next;
    logic                   colon_reg, colon_next, kstart_reg, kstart_next;
    logic                   ktail_reg, ktail_next, ktype_reg, ktype_next;
    logic                   vstart_reg, vstart_next, vtail_reg, vtail_next;
    logic [LENGTH_BITS-1:0] accum_reg, accum_next;
    logic [LENGTH_BITS-1:0] held_reg, held_next;
    logic [4:0]             prefix_reg, prefix_next;
    logic [3:0]             cs_reg, cs_next;
    logic [1:0]             verdict_reg, verdict_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [2:0]             err_reg, err_next;

    logic [7:0]             b, bl;
    logic                   sp;
    logic [1:0]             kind;
    logic [LENGTH_BITS+3:0] prod;
    logic [2:0]             tcode;
    logic [LENGTH_BITS-1:0] left_dec;
    out_item_t              res;

    assign b  = item.in_byte;
    assign bl = lower(b);
    assign sp = (b <= 8'h20);
    assign kind = (key_reg == 4'd14 && !ktype_reg) ? 2'd1 :
                  (key_reg == 4'd12 && ktype_reg) ? 2'd2 : 2'd0;
    assign prod = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
                + {{LENGTH_BITS{1'b0}}, 4'(b - 8'h30)};
    assign tcode = (verdict_reg == TV_TYPE) ? ERR_TYPE :
                   (verdict_reg == TV_CHARSET) ? ERR_CHARSET : ERR_OK;
    assign left_dec = left_reg - 1'b1;

    // Per-byte next-state and result logic.
    always_comb
    begin
        phase_next = phase_reg; key_next = key_reg; colon_next = colon_reg;
        kstart_next = kstart_reg; ktail_next = ktail_reg; ktype_next = ktype_reg;
        vstart_next = vstart_reg; vtail_next = vtail_reg; accum_next = accum_reg;
        held_next = held_reg; prefix_next = prefix_reg; cs_next = cs_reg;
        verdict_next = verdict_reg; left_next = left_reg; err_next = err_reg;
        res = '0;
        res.content_length = OUT_LEN_W'({{32{1'b0}}, held_reg});
        if (err_reg == ERR_OK && item.stream_end) err_next = ERR_LOST;
        if (err_next == ERR_OK) begin
            unique case (phase_reg) inside
                PH_LINE_START, PH_IN_LINE:
                begin
                    if (b == 8'h0D) begin
                        if (phase_reg == PH_LINE_START) phase_next = PH_HEAD_LF;
                        else if (colon_reg && kind == 2'd1 &&
                                 (!vstart_reg || prefix_reg == PREFIX_BAD))
                            err_next = ERR_LENGTH;
                        else begin
                            phase_next = PH_LINE_LF;
                            if (colon_reg && kind == 2'd1) held_next = accum_reg;
                            else if (colon_reg && kind == 2'd2) begin
                                if (prefix_reg != PREFIX_LEN) verdict_next = TV_TYPE;
                                else if ((cs_reg >= 4'd8 && cs_reg <= 4'd12) ||
                                         cs_reg == CS_BAD)
                                    verdict_next = TV_CHARSET;
                                else verdict_next = TV_OK;
                            end
                        end
                    end else if (b == 8'h0A) begin
                        err_next = ERR_BARE_LF;
                    end else begin
                        phase_next = PH_IN_LINE;
                        if (colon_reg) begin
                            // Value byte.
                            if (kind != 2'd0 && !(sp && !vstart_reg)) begin
                                if (sp) vtail_next = 1'b1;
                                else vstart_next = 1'b1;
                                if (kind == 2'd1) begin
                                    if (!sp && prefix_reg != PREFIX_BAD) begin
                                        if (vtail_reg || b < 8'h30 || b > 8'h39)
                                            prefix_next = PREFIX_BAD;
                                        else begin
                                            accum_next = prod[LENGTH_BITS-1:0];
                                            if (prod > {4'd0, LIMIT})
                                                prefix_next = PREFIX_BAD;
                                        end
                                    end
                                end else begin
                                    if (prefix_reg < PREFIX_LEN)
                                        prefix_next = (b == prefix_char(prefix_reg)) ?
                                            prefix_reg + 5'd1 : PREFIX_BAD;
                                    if (cs_reg < 4'd8) begin
                                        if (b == charset_char(cs_reg[2:0]))
                                            cs_next = cs_reg + 4'd1;
                                        else cs_next = (b == "c") ? 4'd1 : 4'd0;
                                    end else begin
                                        case (cs_reg)
                                            4'd8: cs_next = sp ? 4'd8 :
                                                  (b == "u" ? 4'd9 : CS_BAD);
                                            4'd9: cs_next = (b == "t") ? 4'd10 : CS_BAD;
                                            4'd10: cs_next = (b == "f") ? 4'd11 : CS_BAD;
                                            4'd11: cs_next = (b == "-") ? 4'd12 :
                                                   (b == "8" ? 4'd13 : CS_BAD);
                                            4'd12: cs_next = (b == "8") ? 4'd13 : CS_BAD;
                                            4'd13: cs_next = sp ? 4'd13 :
                                                   (b == ";" ? 4'd14 : CS_BAD);
                                            default: cs_next = cs_reg;
                                        endcase
                                    end
                                end
                            end
                        end else if (b == ":") begin
                            colon_next = 1'b1;
                        end else if (sp) begin
                            if (kstart_reg) ktail_next = 1'b1;
                        end else if (ktail_reg) begin
                            key_next = KEY_BAD;
                        end else begin
                            // Key byte.
                            kstart_next = 1'b1;
                            if (key_reg == KEY_BAD) key_next = KEY_BAD;
                            else if (key_reg < 4'd8)
                                key_next = (bl == key_len_char(key_reg)) ?
                                    key_reg + 4'd1 : KEY_BAD;
                            else if (key_reg == 4'd8) begin
                                if (bl == "l") key_next = 4'd9;
                                else if (bl == "t") begin
                                    key_next = 4'd9; ktype_next = 1'b1;
                                end else key_next = KEY_BAD;
                            end else if (ktype_reg)
                                key_next = (key_reg < 4'd12 &&
                                            bl == key_type_char(key_reg)) ?
                                    key_reg + 4'd1 : KEY_BAD;
                            else
                                key_next = (key_reg < 4'd14 &&
                                            bl == key_len_char(key_reg)) ?
                                    key_reg + 4'd1 : KEY_BAD;
                        end
                    end
                end
                PH_LINE_LF, PH_HEAD_LF:
                begin
                    if (b != 8'h0A) err_next = ERR_CR_NO_LF;
                    else begin
                        key_next = '0; colon_next = 1'b0; kstart_next = 1'b0;
                        ktail_next = 1'b0; ktype_next = 1'b0; vstart_next = 1'b0;
                        vtail_next = 1'b0; accum_next = '0; prefix_next = '0;
                        cs_next = '0;
                        phase_next = PH_LINE_START;
                        if (phase_reg == PH_HEAD_LF) begin
                            if (held_reg == '0) begin
                                res.message_end = 1'b1; res.error_code = tcode;
                                verdict_next = TV_OK;
                            end else begin
                                left_next = held_reg;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                default:
                begin
                    res.payload_valid = 1'b1;
                    res.payload_byte = b;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        res.message_end = 1'b1; res.error_code = tcode;
                        held_next = '0; verdict_next = TV_OK;
                        phase_next = PH_LINE_START;
                    end
                end
            endcase
        end
        if (err_next != ERR_OK) begin
            res.payload_valid = 1'b0; res.payload_byte = '0;
            res.message_end = 1'b0; res.error_code = err_next;
        end
    end

    assign result = res;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_LINE_START; key_reg <= '0; colon_reg <= 1'b0;
            kstart_reg <= 1'b0; ktail_reg <= 1'b0; ktype_reg <= 1'b0;
            vstart_reg <= 1'b0; vtail_reg <= 1'b0; accum_reg <= '0;
            held_reg <= '0; prefix_reg <= '0; cs_reg <= '0;
            verdict_reg <= TV_OK; left_reg <= '0; err_reg <= ERR_OK;
        end else if (step) begin
            phase_reg <= phase_next; key_reg <= key_next; colon_reg <= colon_next;
            kstart_reg <= kstart_next; ktail_reg <= ktail_next;
            ktype_reg <= ktype_next; vstart_reg <= vstart_next;
            vtail_reg <= vtail_next; accum_reg <= accum_next;
            held_reg <= held_next; prefix_reg <= prefix_next; cs_reg <= cs_next;
            verdict_reg <= verdict_next; left_reg <= left_next;
            err_reg <= err_next;
        end
    end

endmodule

// ----- rtl/header_framed_message_deframer_core.sv -----
// Channel  Role    Payload
// in_ch    sink    in_byte, stream_end
// out_ch   source  payload_valid, payload_byte, message_end, error_code, content_length
// One byte is taken per cycle while the result side is not stalled; it is parsed from the
// input register into the result register when the input register moves on.
// A new byte is taken whenever the input register is empty or moves on, which it does
// when the result register is empty or drained in the same cycle: one per cycle.
// rst_n clears the valid flags and parser state asynchronously; a framing error then sticks until reset.
module header_framed_message_deframer_core
    import hfmd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    hfmd_stream_if.sink   in_ch,
    hfmd_stream_if.source out_ch
);

    logic      in_vld_reg, out_vld_reg, step, advance;
    in_item_t  in_reg;
    out_item_t out_reg, res;

    // The input stage moves on when the result stage can take its output.
    assign advance = !out_vld_reg || out_ch.ready;
    assign step = in_vld_reg && advance;
    assign in_ch.ready = !in_vld_reg || advance;

    hfmd_parse #(.LENGTH_BITS(LENGTH_BITS)) u_parse (
        .clk(clk), .rst_n(rst_n), .step(step), .item(in_reg), .result(res)
    );

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_ch.ready) in_vld_reg <= in_ch.valid;
            if (advance) out_vld_reg <= in_vld_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready) in_reg <= in_ch.data;
        if (step) out_reg <= res;
    end

    assign out_ch.valid = out_vld_reg;
    assign out_ch.data = out_reg;

endmodule

// ----- rtl/hfmd_checker.sv -----
`include "header_framed_message_deframer_core_defines.svh"
module hfmd_checker
    import hfmd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A held result must stay put while stalled.
    `HFMD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
    // A framing-error result must not flag a payload byte or a message end.
    `HFMD_ASSERT_IMP(a_err_pv, clk, rst_n, out_valid && out_data.error_code != ERR_OK && out_data.error_code != ERR_TYPE && out_data.error_code != ERR_CHARSET, !out_data.payload_valid && !out_data.message_end, "error result carries data")
    // Type errors appear only with a message end.
    `HFMD_ASSERT_IMP(a_type_end, clk, rst_n, out_valid && (out_data.error_code == ERR_TYPE || out_data.error_code == ERR_CHARSET), out_data.message_end, "type error without message end")
    // An empty output stage never refuses input.
    `HFMD_ASSERT_IMP(a_ready, clk, rst_n, !out_valid, in_ready, "stalled with free output")

endmodule

bind header_framed_message_deframer_core hfmd_checker u_hfmd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ----- verif/hfmd_deframer_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, predicts each result from the accepted bytes and
// compares it with what the block delivers.
module hfmd_deframer_checker
    import hfmd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    hfmd_stream_if in_ch,
    hfmd_stream_if out_ch,
    output int     fail_count,
    output int     pending
);

    localparam logic [7:0] CR = 8'h0D;
    localparam logic [7:0] LF = 8'h0A;
    localparam logic [31:0] LEN_MAX = 32'h00FF_FFFF;
    localparam string LEN_KEY = "content-length";
    localparam string TYPE_KEY = "content-type";
    localparam string MEDIA_PREFIX = {"application/vs", "code-jsonrpc"};
    localparam string CHARSET_KEY = "charset=";

    // Predicted parser state.
    phase_t      phase;
    logic [3:0]  kpos;
    logic        has_colon, key_started, key_tail, is_type, val_started, val_tail;
    logic [31:0] accum;
    logic [23:0] held;
    logic [4:0]  ppos;
    logic [3:0]  cpos;
    logic [1:0]  verdict;
    logic [23:0] left;
    logic [2:0]  sticky;

    out_item_t expected_results[$];

    assign pending = expected_results.size();

    function automatic bit blank(input logic [7:0] b);
        return b <= 8'h20;
    endfunction

    // 1 for the length key, 2 for the type key, 0 for anything else.
    function automatic int key_kind();
        if (kpos == 4'd14 && !is_type) return 1;
        if (kpos == 4'd12 && is_type) return 2;
        return 0;
    endfunction

    task automatic clear_line();
        kpos = 0; has_colon = 0; key_started = 0; key_tail = 0; is_type = 0;
        val_started = 0; val_tail = 0; accum = 0; ppos = 0; cpos = 0;
    endtask

    task automatic match_key(input logic [7:0] raw);
        logic [7:0] b;
        b = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
        if (kpos == KEY_BAD) return;
        if (kpos < 4'd8) begin
            kpos = (b == LEN_KEY[kpos]) ? kpos + 4'd1 : KEY_BAD;
        end
        else if (kpos == 4'd8) begin
            if (b == "l") kpos = 4'd9;
            else if (b == "t") begin
                kpos = 4'd9;
                is_type = 1;
            end
            else kpos = KEY_BAD;
        end
        else if (is_type) begin
            kpos = (kpos < 4'd12 && b == TYPE_KEY[kpos]) ? kpos + 4'd1 : KEY_BAD;
        end
        else begin
            kpos = (kpos < 4'd14 && b == LEN_KEY[kpos]) ? kpos + 4'd1 : KEY_BAD;
        end
    endtask

    task automatic match_charset(input logic [7:0] b);
        if (cpos < 4'd8) begin
            if (b == CHARSET_KEY[cpos]) cpos = cpos + 4'd1;
            else cpos = (b == "c") ? 4'd1 : 4'd0;
            return;
        end
        case (cpos)
            4'd8:  cpos = blank(b) ? 4'd8 : (b == "u" ? 4'd9 : CS_BAD);
            4'd9:  cpos = (b == "t") ? 4'd10 : CS_BAD;
            4'd10: cpos = (b == "f") ? 4'd11 : CS_BAD;
            4'd11: cpos = (b == "-") ? 4'd12 : (b == "8" ? 4'd13 : CS_BAD);
            4'd12: cpos = (b == "8") ? 4'd13 : CS_BAD;
            4'd13: cpos = blank(b) ? 4'd13 : (b == ";" ? 4'd14 : CS_BAD);
            default: ;
        endcase
    endtask

    task automatic take_value(input logic [7:0] b);
        int k;
        k = key_kind();
        if (k == 0) return;
        if (blank(b)) begin
            if (!val_started) return;
            val_tail = 1;
        end
        else val_started = 1;
        if (k == 1) begin
            if (blank(b) || ppos == PREFIX_BAD) return;
            if (val_tail || b < "0" || b > "9") begin
                ppos = PREFIX_BAD;
                return;
            end
            accum = accum * 10 + (b - "0");
            if (accum > LEN_MAX) ppos = PREFIX_BAD;
        end
        else begin
            if (ppos < PREFIX_LEN)
                ppos = (b == MEDIA_PREFIX[ppos]) ? ppos + 5'd1 : PREFIX_BAD;
            match_charset(b);
        end
    endtask

    task automatic take_line_byte(input logic [7:0] b);
        if (has_colon) take_value(b);
        else if (b == ":") has_colon = 1;
        else if (blank(b)) begin
            if (key_started) key_tail = 1;
        end
        else if (key_tail) kpos = KEY_BAD;
        else begin
            key_started = 1;
            match_key(b);
        end
    endtask

    // Closes a header line; ok is low when a length value is malformed.
    task automatic close_line(output bit ok);
        int k;
        ok = 1;
        if (!has_colon) return;
        k = key_kind();
        if (k == 1) begin
            if (!val_started || ppos == PREFIX_BAD) ok = 0;
            else held = accum[23:0];
        end
        else if (k == 2) begin
            if (ppos != PREFIX_LEN) verdict = TV_TYPE;
            else if ((cpos >= 4'd8 && cpos <= 4'd12) || cpos == CS_BAD) verdict = TV_CHARSET;
            else verdict = TV_OK;
        end
    endtask

    function automatic logic [2:0] verdict_code();
        return verdict == TV_TYPE ? ERR_TYPE : (verdict == TV_CHARSET ? ERR_CHARSET : ERR_OK);
    endfunction

    task automatic deframe(input logic [7:0] b, input logic ended, output out_item_t r);
        bit ok;
        r = '0;
        r.content_length = held;
        if (sticky == ERR_OK && ended) sticky = ERR_LOST;
        if (sticky == ERR_OK) begin
            case (phase) inside
                PH_LINE_START, PH_IN_LINE:
                begin
                    if (b == CR) begin
                        if (phase == PH_LINE_START) phase = PH_HEAD_LF;
                        else begin
                            close_line(ok);
                            if (ok) phase = PH_LINE_LF;
                            else sticky = ERR_LENGTH;
                        end
                    end
                    else if (b == LF) sticky = ERR_BARE_LF;
                    else begin
                        phase = PH_IN_LINE;
                        take_line_byte(b);
                    end
                end
                PH_LINE_LF:
                begin
                    if (b == LF) begin
                        clear_line();
                        phase = PH_LINE_START;
                    end
                    else sticky = ERR_CR_NO_LF;
                end
                PH_HEAD_LF:
                begin
                    if (b != LF) sticky = ERR_CR_NO_LF;
                    else begin
                        clear_line();
                        if (held == 0) begin
                            r.message_end = 1;
                            r.error_code = verdict_code();
                            verdict = TV_OK;
                            phase = PH_LINE_START;
                        end
                        else begin
                            left = held;
                            phase = PH_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    r.payload_valid = 1;
                    r.payload_byte = b;
                    left = left - 24'd1;
                    if (left == 0) begin
                        r.message_end = 1;
                        r.error_code = verdict_code();
                        held = 0;
                        verdict = TV_OK;
                        phase = PH_LINE_START;
                    end
                end
            endcase
        end
        if (sticky != ERR_OK) begin
            r.payload_valid = 0;
            r.payload_byte = 0;
            r.message_end = 0;
            r.error_code = sticky;
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        clear_line();
        phase = PH_LINE_START;
        held = 0; verdict = TV_OK; left = 0; sticky = ERR_OK;
    end

    // Predict on each input transfer and check each result transfer.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_results.size() == 0) begin
                    report("unexpected result", 0, 0);
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.payload_valid !== want.payload_valid)
                        report("payload_valid", got.payload_valid, want.payload_valid);
                    if (got.payload_byte !== want.payload_byte)
                        report("payload_byte", got.payload_byte, want.payload_byte);
                    if (got.message_end !== want.message_end)
                        report("message_end", got.message_end, want.message_end);
                    if (got.error_code !== want.error_code)
                        report("error_code", got.error_code, want.error_code);
                    if (got.content_length !== want.content_length)
                        report("content_length", got.content_length, want.content_length);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                deframe(in_ch.data.in_byte, in_ch.data.stream_end, want);
                expected_results.insert(expected_results.size(), want);
            end
        end
    end

endmodule

// ----- verif/tb_header_framed_message_deframer_core.sv -----
`timescale 1ns / 1ps

module tb_header_framed_message_deframer_core;
    import hfmd_pkg::*;

    localparam int RANDOM_BYTES = 800;
    localparam int QUIET_AFTER = 700;
    localparam int STALL_LIMIT = 5000;
    localparam string MEDIA_PREFIX = {"application/vs", "code-jsonrpc"};

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   quiet;
    int   bytes_sent;
    int   idle_cycles;

    logic [7:0] stream_bytes[$];

    hfmd_stream_if #(.payload_t(in_item_t))  in_ch();
    hfmd_stream_if #(.payload_t(out_item_t)) out_ch();

    header_framed_message_deframer_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    hfmd_deframer_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Result side: ready drops in random bursts until the quiet part of the run.
    int stall_left;
    always @(posedge clk)
    begin
        if (!rst_n || quiet) out_ch.ready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            out_ch.ready <= 1'b0;
        end
        else out_ch.ready <= 1'b1;
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("header_framed_message_deframer_core verification failed");
            $finish;
        end
    end

    // Appends one byte to the stream still to be sent.
    task automatic queue_byte(input logic [7:0] b);
        stream_bytes = {stream_bytes, b};
    endtask

    function automatic logic [7:0] pad_byte();
        logic [7:0] pads[4] = '{8'h20, 8'h09, 8'h00, 8'h1F};
        return pads[$urandom_range(0, 3)];
    endfunction

    // Any header text byte other than CR and LF.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = $urandom_range(0, 255);
        if (b == 8'h0D || b == 8'h0A) b = "x";
        return b;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic add_pads(input int most);
        int n;
        n = $urandom_range(0, most);
        repeat (n) queue_byte(pad_byte());
    endtask

    // Key in a random mix of cases, optionally padded on both sides.
    task automatic add_key(input string s);
        logic [7:0] c;
        add_pads(2);
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
            queue_byte(c);
        end
        add_pads(2);
        queue_byte(":");
        add_pads(2);
    endtask

    task automatic add_length_line(input int unsigned value);
        add_key("content-length");
        repeat ($urandom_range(0, 2)) queue_byte("0");
        add_text($sformatf("%0d", value));
        add_pads(2);
        add_text("\r\n");
    endtask

    task automatic add_type_line(input int variant);
        add_key("content-type");
        case (variant)
            0: add_text(MEDIA_PREFIX);
            1: add_text({MEDIA_PREFIX, "; charset=utf-8"});
            2: add_text({MEDIA_PREFIX, ";charset=utf8"});
            3: add_text({MEDIA_PREFIX, "; charset= utf-8 ;q"});
            4: add_text({MEDIA_PREFIX, "; charset=latin1"});
            5: add_text({MEDIA_PREFIX, "; charset=utf"});
            6: add_text("text/plain");
            default: add_text("application/json");
        endcase
        add_pads(2);
        add_text("\r\n");
    endtask

    // A well-formed message with random headers and content.
    task automatic add_message();
        int unsigned len;
        int n;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: add_text("x-note: ");
                1: add_text("content-len: 4");
                2: add_text("Content-Length");
                default: ;
            endcase
            n = $urandom_range(0, 6);
            repeat (n) queue_byte(text_byte());
            add_text("\r\n");
        end
        if ($urandom_range(0, 4) == 0) add_length_line(24'hFF_FFFF);
        if ($urandom_range(0, 4) == 0) add_type_line($urandom_range(0, 7));
        if (len != 0 || $urandom_range(0, 1)) add_length_line(len);
        if ($urandom_range(0, 2) == 0) add_type_line($urandom_range(0, 7));
        add_text("\r\n");
        repeat (len) queue_byte($urandom_range(0, 255));
    endtask

    // One input transfer, with a random gap in front of it outside the quiet part.
    task automatic send_byte(input logic [7:0] b, input logic ended);
        in_item_t item;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item.in_byte = b;
        item.stream_end = ended;
        in_ch.valid <= 1'b1;
        in_ch.data <= item;
        do @(posedge clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (stream_bytes.size() != 0) begin
            send_byte(stream_bytes.pop_front(), 1'b0);
            if (bytes_sent >= QUIET_AFTER) quiet = 1;
        end
    endtask

    initial
    begin
        int guard;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        quiet = 0;
        bytes_sent = 0;
        idle_cycles = 0;
        stall_left = 0;
        guard = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed messages: extreme bytes, empty content, each type verdict,
        // a maximum length that a later duplicate replaces.
        add_text("Content-Length: 2\r\n\r\n");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        add_text("\r\n");
        add_type_line(1);
        add_text("\r\n");
        add_type_line(4);
        add_length_line(1);
        add_text("\r\nz");
        add_type_line(6);
        add_text("\r\n");
        add_length_line(24'hFF_FFFF);
        add_text("bogus line\r\n CONTENT-length :  3 \r\n\r\nabc");
        send_queued();

        // Random well-formed traffic, with one pause until the block drains.
        while (bytes_sent < RANDOM_BYTES) begin
            add_message();
            send_queued();
            if (bytes_sent > RANDOM_BYTES / 2 && guard == 0) begin
                guard = 1;
                in_ch.valid <= 1'b0;
                while (pending != 0) @(posedge clk);
            end
        end

        // One framing error to close the run, since it sticks until reset.
        case ($urandom_range(0, 4))
            0: ;
            1: add_text("Content-Length: 4\n");
            2: add_text("x-a: b\rq");
            3: add_text("content-length: 1 2\r\n");
            default: add_text("content-length: 16777216\r\n");
        endcase
        repeat ($urandom_range(1, 4)) queue_byte($urandom_range(0, 255));
        send_queued();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        in_ch.valid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < STALL_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("header_framed_message_deframer_core verification clean");
        else
            $display("header_framed_message_deframer_core verification failed");
        $finish;
    end

endmodule
